// File: hw/rtl/tlbpa_pkg.sv
package tlbpa_pkg;

    localparam int MAX_PAGES_DEF   = 65536;
    localparam int SUPER_PAGES_DEF = 1024;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int PAGE_SHIFT_DEF  = 12;

    localparam logic [8:0]  LOWER_RST  = 9'd160;
    localparam logic [16:0] TOTAL_RST  = 17'd65536;
    localparam logic [16:0] FREE_MAX   = 17'h1FFFF;
    localparam logic [31:0] UPPER_BASE = 32'h0010_0000;

    localparam logic [2:0] CMD_ALLOC      = 3'd0;
    localparam logic [2:0] CMD_FREE       = 3'd1;
    localparam logic [2:0] CMD_ALLOC_RNG  = 3'd2;
    localparam logic [2:0] CMD_FREE_RNG   = 3'd3;
    localparam logic [2:0] CMD_CNT_UP     = 3'd4;
    localparam logic [2:0] CMD_CNT_DOWN   = 3'd5;

    localparam logic [1:0] CFG_LOWER = 2'd0;
    localparam logic [1:0] CFG_TOTAL = 2'd1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_CONFLICT = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    decode;
        logic    scan_init;
        logic    scan_ex;
        logic    chk_init;
        logic    chk_ex;
        logic    swp_init;
        logic    swp_ex;
        logic    cnt_wr;
        logic    done;
        t_status status;
    } t_dp_ctl;

    typedef struct packed {
        logic clr_done;
        logic is_alloc;
        logic is_free;
        logic is_range;
        logic is_count;
        logic oor;
        logic empty;
        logic fc_zero;
        logic super_none;
        logic word_nz;
        logic idx_oor;
        logic scan_last;
        logic conflict;
        logic chk_last;
        logic swp_last;
    } t_dp_sts;

endpackage

// File: hw/rtl/tlbpa_ram.sv
module tlbpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tlbpa_ctrl.sv
module tlbpa_ctrl import tlbpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_EX,
        S_CHK_RD,
        S_CHK_EX,
        S_SWP_INIT,
        S_SWP_RD,
        S_SWP_EX,
        S_CNT_EX,
        S_FIN
    } t_state;

    t_state  r_state;
    t_status r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_status <= ST_OK;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_done) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) r_state <= S_DECODE;
                end
                S_DECODE: r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    priority if (i_sts.is_alloc) begin
                        if (i_sts.fc_zero || i_sts.super_none) begin
                            r_status <= ST_OOM;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end else if (i_sts.is_free || i_sts.is_range) begin
                        if (i_sts.oor) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_FIN;
                        end else if (i_sts.empty) begin
                            r_status <= ST_OK;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_CHK_RD;
                        end
                    end else if (i_sts.is_count) begin
                        if (i_sts.oor) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_CNT_EX;
                        end
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_FIN;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_EX;
                S_SCAN_EX: begin
                    priority if (i_sts.word_nz) begin
                        if (i_sts.idx_oor) begin
                            r_status <= ST_OOM;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_SWP_INIT;
                        end
                    end else if (i_sts.scan_last) begin
                        r_status <= ST_OOM;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_SCAN_RD;
                    end
                end
                S_CHK_RD: r_state <= S_CHK_EX;
                S_CHK_EX: begin
                    priority if (i_sts.conflict) begin
                        r_status <= ST_CONFLICT;
                        r_state  <= S_FIN;
                    end else if (i_sts.chk_last) begin
                        r_state <= S_SWP_INIT;
                    end else begin
                        r_state <= S_CHK_RD;
                    end
                end
                S_SWP_INIT: r_state <= S_SWP_RD;
                S_SWP_RD:   r_state <= S_SWP_EX;
                S_SWP_EX: begin
                    if (i_sts.swp_last) begin
                        r_status <= ST_OK;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_SWP_RD;
                    end
                end
                S_CNT_EX: begin
                    r_status <= ST_OK;
                    r_state  <= S_FIN;
                end
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_ctl           = '0;
        o_ctl.status    = r_status;
        o_ctl.clr_step  = (r_state == S_CLEAR);
        o_ctl.load      = (r_state == S_IDLE) && i_start;
        o_ctl.decode    = (r_state == S_DECODE);
        o_ctl.scan_init = (r_state == S_DISPATCH);
        o_ctl.chk_init  = (r_state == S_DISPATCH);
        o_ctl.scan_ex   = (r_state == S_SCAN_EX);
        o_ctl.chk_ex    = (r_state == S_CHK_EX);
        o_ctl.swp_init  = (r_state == S_SWP_INIT);
        o_ctl.swp_ex    = (r_state == S_SWP_EX);
        o_ctl.cnt_wr    = (r_state == S_CNT_EX);
        o_ctl.done      = (r_state == S_FIN);
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hw/rtl/tlbpa_dp.sv
module tlbpa_dp import tlbpa_pkg::*; #(
    parameter int MAX_PAGES   = MAX_PAGES_DEF,
    parameter int SUPER_PAGES = SUPER_PAGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_page_addr,
    input  logic [31:0] i_end_addr,
    input  logic [8:0]  i_lower_pages,
    input  logic [16:0] i_total_pages,
    input  t_dp_ctl     i_ctl,
    output t_dp_sts     o_sts,
    output logic        o_valid,
    output logic [31:0] o_result_addr,
    output logic [15:0] o_use_count,
    output logic [1:0]  o_status,
    output logic [16:0] o_free_pages
);

    localparam int IW   = $clog2(MAX_PAGES);
    localparam int PW   = (MAX_PAGES + 63) / 64;
    localparam int WAW  = $clog2(PW);
    localparam int WW   = IW - 5;
    localparam int WPS  = SUPER_PAGES / 64;
    localparam int WPSB = $clog2(WPS);
    localparam int NS   = (MAX_PAGES + SUPER_PAGES - 1) / SUPER_PAGES;
    localparam int SW   = (NS > 1) ? $clog2(NS) : 1;
    localparam int PGW  = 32 - PAGE_SHIFT;
    localparam int LW   = $clog2(MAX_PAGES + 1);
    localparam int CW0  = (PGW + 1 > 17) ? PGW + 1 : 17;
    localparam int CW   = (CW0 > LW) ? CW0 : LW;
    localparam int FW   = (IW + 2 > 18) ? IW + 2 : 18;

    localparam logic [WW-1:0] WPSM  = WW'(WPS - 1);
    localparam logic [WW-1:0] LASTW = WW'(PW - 1);

    logic [2:0]             r_cmd;
    logic [31:0]            r_a;
    logic [31:0]            r_e;
    logic [IW:0]            r_lo;
    logic [IW:0]            r_hi;
    logic                   r_oor;
    logic                   r_empty;
    logic [WW-1:0]          r_wptr;
    logic                   r_acc;
    logic [NS-1:0]          r_super;
    logic [16:0]            r_fc;
    logic [IW-1:0]          r_clr;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic                   r_vld;
    logic [31:0]            r_res_addr;
    logic [15:0]            r_use;
    t_status                r_stat;
    logic [16:0]            r_free;

    logic [CW-1:0]          limit;
    logic [CW:0]            m_as;
    logic [CW:0]            m_ae;
    logic [CW:0]            m_ee;
    logic [IW:0]            n_lo;
    logic [IW:0]            n_hi;
    logic                   n_oor;
    logic                   n_empty;
    logic                   is_alloc;
    logic                   is_free;
    logic                   is_range;
    logic                   is_count;
    logic                   to_free;
    logic [WW-1:0]          lo_w;
    logic [WW-1:0]          hi_w;
    logic [IW:0]            hm1;
    logic [WW-1:0]          chk_last_w;
    logic [63:0]            mlo;
    logic [63:0]            mhi;
    logic [63:0]            mask;
    logic [63:0]            pg_rdata;
    logic [63:0]            new_word;
    logic [5:0]             fb;
    logic [SW-1:0]          fs;
    logic [IW:0]            found_idx;
    logic                   super_end;
    logic [SW-1:0]          sidx;
    logic                   clr_in_pw;
    logic                   pg_we;
    logic [WAW-1:0]         pg_waddr;
    logic [63:0]            pg_wdata;
    logic                   cn_we;
    logic [IW-1:0]          cn_waddr;
    logic [COUNT_WIDTH-1:0] cn_wdata;
    logic [COUNT_WIDTH-1:0] cn_rdata;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [FW-1:0]          nn;
    logic [FW-1:0]          fc_x;
    logic [FW-1:0]          fc_sum;
    logic [16:0]            n_fc;
    logic [31:0]            lo_addr;
    logic [31:0]            lo_x;
    logic [31:0]            lp_x;

    // page number of an address; upper memory pages are numbered on after the lower page count
    function automatic logic [CW:0] map_addr(input logic [31:0] addr, input logic is_end,
                                             input logic [8:0] lp, input logic [CW-1:0] lim);
        logic [CW-1:0] pg;
        logic [CW-1:0] upg;
        logic [CW-1:0] lpx;
        logic [CW-1:0] idx;
        logic          lo_hit;
        logic          up_hit;
        logic          in_lim;
        pg     = CW'(addr >> PAGE_SHIFT);
        upg    = CW'((addr - UPPER_BASE) >> PAGE_SHIFT);
        lpx    = CW'(lp);
        lo_hit = (pg < lpx) || (is_end && (pg == lpx));
        up_hit = (addr >= UPPER_BASE);
        idx    = lo_hit ? pg : CW'(upg + lpx);
        in_lim = is_end ? (idx <= lim) : (idx < lim);
        return {(lo_hit || up_hit) && in_lim, idx};
    endfunction

    assign limit = (CW'(i_total_pages) < CW'(MAX_PAGES)) ? CW'(i_total_pages) : CW'(MAX_PAGES);

    assign is_alloc = (r_cmd == CMD_ALLOC);
    assign is_free  = (r_cmd == CMD_FREE);
    assign is_range = (r_cmd == CMD_ALLOC_RNG) || (r_cmd == CMD_FREE_RNG);
    assign is_count = (r_cmd == CMD_CNT_UP) || (r_cmd == CMD_CNT_DOWN);
    assign to_free  = (r_cmd == CMD_FREE) || (r_cmd == CMD_FREE_RNG);

    assign m_as = map_addr(r_a, 1'b0, i_lower_pages, limit);
    assign m_ae = map_addr(r_a, 1'b1, i_lower_pages, limit);
    assign m_ee = map_addr(r_e, 1'b1, i_lower_pages, limit);

    always_comb begin
        n_lo    = (IW+1)'(m_as[CW-1:0]);
        n_hi    = (IW+1)'(m_as[CW-1:0] + CW'(1));
        n_oor   = !m_as[CW];
        n_empty = 1'b0;
        if (is_range) begin
            n_hi = (IW+1)'(m_ee[CW-1:0]);
            if (!(m_as[CW] && m_ee[CW])) begin
                // an empty range right at the top end is still accepted
                n_empty = m_ee[CW] && m_ae[CW] && (m_ae[CW-1:0] == m_ee[CW-1:0]);
                n_oor   = !n_empty;
            end else begin
                n_oor   = (m_ee[CW-1:0] < m_as[CW-1:0]);
                n_empty = (m_ee[CW-1:0] == m_as[CW-1:0]);
            end
        end
    end

    // bitmap word bounds of the page window [lo, hi)
    assign lo_w       = r_lo[IW:6];
    assign hi_w       = r_hi[IW:6];
    assign hm1        = r_hi - (IW+1)'(1);
    assign chk_last_w = hm1[IW:6];

    always_comb begin
        if (r_wptr == lo_w) mlo = {64{1'b1}} << r_lo[5:0];
        else                mlo = (r_wptr > lo_w) ? {64{1'b1}} : '0;
        if (r_wptr == hi_w) mhi = ~({64{1'b1}} << r_hi[5:0]);
        else                mhi = (r_wptr < hi_w) ? {64{1'b1}} : '0;
        mask = mlo & mhi;
    end

    assign new_word = to_free ? (pg_rdata | mask) : (pg_rdata & ~mask);

    always_comb begin
        fb = '0;
        for (int b = 63; b >= 0; b--) begin
            if (pg_rdata[b]) fb = 6'(b);
        end
    end

    always_comb begin
        fs = '0;
        for (int k = NS - 1; k >= 0; k--) begin
            if (r_super[k]) fs = SW'(k);
        end
    end

    assign found_idx = {r_wptr, fb};
    assign super_end = ((r_wptr & WPSM) == WPSM) || (r_wptr == LASTW);
    assign sidx      = SW'(r_wptr >> WPSB);
    assign clr_in_pw = ({1'b0, r_clr} < (IW+1)'(PW));

    always_comb begin
        o_sts            = '0;
        o_sts.clr_done   = (r_clr == IW'(MAX_PAGES - 1));
        o_sts.is_alloc   = is_alloc;
        o_sts.is_free    = is_free;
        o_sts.is_range   = is_range;
        o_sts.is_count   = is_count;
        o_sts.oor        = r_oor;
        o_sts.empty      = r_empty;
        o_sts.fc_zero    = (r_fc == '0);
        o_sts.super_none = !(|r_super);
        o_sts.word_nz    = |pg_rdata;
        o_sts.idx_oor    = (CW'(found_idx) >= limit);
        o_sts.scan_last  = super_end;
        o_sts.conflict   = to_free ? |(pg_rdata & mask) : |(~pg_rdata & mask);
        o_sts.chk_last   = (r_wptr == chk_last_w);
        o_sts.swp_last   = (r_wptr == (chk_last_w | WPSM)) || (r_wptr == LASTW);
    end

    // memory ports
    assign pg_we    = (i_ctl.clr_step && clr_in_pw) || i_ctl.swp_ex;
    assign pg_waddr = i_ctl.clr_step ? r_clr[WAW-1:0] : r_wptr[WAW-1:0];
    assign pg_wdata = i_ctl.clr_step ? {64{1'b1}} : new_word;

    assign cnt_next = (r_cmd == CMD_CNT_UP) ? cn_rdata + COUNT_WIDTH'(1)
                                            : cn_rdata - COUNT_WIDTH'(1);
    assign cn_we    = i_ctl.clr_step || i_ctl.cnt_wr;
    assign cn_waddr = i_ctl.clr_step ? r_clr : r_lo[IW-1:0];
    assign cn_wdata = i_ctl.clr_step ? '0 : cnt_next;

    tlbpa_ram #(
        .WIDTH (64),
        .DEPTH (PW)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (r_wptr[WAW-1:0]),
        .o_rdata (pg_rdata)
    );

    tlbpa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_PAGES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cn_we),
        .i_waddr (cn_waddr),
        .i_wdata (cn_wdata),
        .i_raddr (r_lo[IW-1:0]),
        .o_rdata (cn_rdata)
    );

    // free count, saturating at both ends
    assign nn     = FW'(r_hi - r_lo);
    assign fc_x   = FW'(r_fc);
    assign fc_sum = fc_x + nn;
    always_comb begin
        if (to_free) n_fc = (fc_sum > FW'(FREE_MAX)) ? FREE_MAX : 17'(fc_sum);
        else         n_fc = (fc_x > nn) ? 17'(fc_x - nn) : '0;
    end

    assign lo_x    = 32'(r_lo);
    assign lp_x    = 32'(i_lower_pages);
    assign lo_addr = (lo_x < lp_x) ? (lo_x << PAGE_SHIFT)
                                   : ((lo_x - lp_x) << PAGE_SHIFT) + UPPER_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_super <= '1;
            r_fc    <= TOTAL_RST;
            r_clr   <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (i_ctl.clr_step) r_clr <= r_clr + IW'(1);
            if (i_ctl.swp_ex) begin
                if (super_end) r_super[sidx] <= r_acc || (|new_word);
                if (o_sts.swp_last) r_fc <= n_fc;
            end
            r_vld <= i_ctl.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_a   <= i_page_addr;
            r_e   <= i_end_addr;
        end
        if (i_ctl.decode) begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_oor   <= n_oor;
            r_empty <= n_empty;
        end
        if (i_ctl.scan_ex && o_sts.word_nz) begin
            r_lo <= found_idx;
            r_hi <= found_idx + (IW+1)'(1);
        end
        if (i_ctl.scan_init && is_alloc) begin
            r_wptr <= WW'(WW'(fs) << WPSB);
        end else if (i_ctl.chk_init && !is_alloc) begin
            r_wptr <= lo_w;
        end else if (i_ctl.swp_init) begin
            r_wptr <= lo_w & ~WPSM;
        end else if (i_ctl.scan_ex || i_ctl.chk_ex || i_ctl.swp_ex) begin
            r_wptr <= r_wptr + WW'(1);
        end
        if (i_ctl.swp_init) begin
            r_acc <= 1'b0;
        end else if (i_ctl.swp_ex) begin
            r_acc <= super_end ? 1'b0 : (r_acc || (|new_word));
        end
        if (i_ctl.cnt_wr) r_cnt <= cnt_next;
        if (i_ctl.done) begin
            r_res_addr <= (is_alloc && i_ctl.status == ST_OK) ? lo_addr : '0;
            r_use      <= (is_count && i_ctl.status == ST_OK) ? 16'(r_cnt) : '0;
            r_stat     <= i_ctl.status;
            r_free     <= r_fc;
        end
    end

    assign o_valid       = r_vld;
    assign o_result_addr = r_res_addr;
    assign o_use_count   = r_use;
    assign o_status      = r_stat;
    assign o_free_pages  = r_free;

endmodule

// File: hw/rtl/two_level_bitmap_page_allocator_top.sv
// Physical page allocator with a free bit per page, a summary bit per superpage and a use
// counter per page. A request is taken when start is high and busy is low; its single result
// appears on the o_ ports for exactly one cycle with o_valid, and the receiver cannot hold it
// off. Work goes through the page bitmap RAM one 64-bit word at a time, each word with a read
// state and an execute state. Count up or down updates the use counter of the page. Free page
// and range requests check the words of their window and then sweep the words of the touched
// superpages; alloc page scans the words of the first superpage marked free and then sweeps
// that superpage. Address errors, empty ranges, unknown commands and an alloc with nothing free
// go straight to the result; a conflict is reported right after the check pass. After
// reset a clearing pass fills the bitmap and zeroes the counters, with busy high. Configuration
// writes are always ready and must only happen while the block is idle.
module two_level_bitmap_page_allocator_top import tlbpa_pkg::*; #(
    parameter int MAX_PAGES   = MAX_PAGES_DEF,
    parameter int SUPER_PAGES = SUPER_PAGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_page_addr,
    input  logic [31:0] i_end_addr,
    output logic        o_valid,
    output logic [31:0] o_result_addr,
    output logic [15:0] o_use_count,
    output logic [1:0]  o_status,
    output logic [16:0] o_free_pages,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    logic [8:0]  r_lower;
    logic [16:0] r_total;
    t_dp_ctl     ctl;
    t_dp_sts     sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= LOWER_RST;
            r_total <= TOTAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOWER: r_lower <= i_cfg_data[8:0];
                CFG_TOTAL: r_total <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    tlbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    tlbpa_dp #(
        .MAX_PAGES   (MAX_PAGES),
        .SUPER_PAGES (SUPER_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_page_addr   (i_page_addr),
        .i_end_addr    (i_end_addr),
        .i_lower_pages (r_lower),
        .i_total_pages (r_total),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_result_addr (o_result_addr),
        .o_use_count   (o_use_count),
        .o_status      (o_status),
        .o_free_pages  (o_free_pages)
    );

endmodule
